// ===== sv/qslerp_pkg.sv =====
// shared types, constants and helpers for the quaternion slerp pipeline
package qslerp_pkg;

    // fixed point format of all ports
    localparam int FRAC_BITS = 14;
    localparam int ONE = 1 << FRAC_BITS;

    // internal arithmetic sizes
    localparam int ACC_W = 64;
    localparam int QUO_W = 32;
    localparam int CW_W = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS = 32;
    localparam int LDIV_STEPS = 16;
    localparam int WDIV_STEPS = 32;
    localparam logic [31:0] CORDIC_KINV = 32'd652032874;

    // atan(2^-i) in Q1.30
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
        32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
        32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
        32'd32, 32'd16, 32'd8, 32'd4, 32'd2
    };

    // configuration register indexes
    localparam logic REG_COS_THRESHOLD = 1'b0;
    localparam logic REG_LENGTH_FLOOR = 1'b1;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic [14:0]        blend;
    } in_t;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
        logic               degenerate;
    } out_t;

    // everything one request carries down the pipeline
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] b2;
        logic [14:0]      t;
        logic [3:0][31:0] prod;
        logic [33:0]      dot;
        logic             lin_thr;
        logic [30:0]      cw;
        logic [3:0][17:0] diff;
        logic [60:0]      cwsq;
        logic [3:0][32:0] ldp;
        logic [60:0]      rad;
        logic [3:0][17:0] r;
        logic [3:0][35:0] rsq;
        logic [37:0]      sq;
        logic [30:0]      s;
        logic [20:0]      len;
        logic             use_lin;
        logic             lin_deg;
        logic [3:0]       lneg;
        logic [3:0]       lovf;
        logic [3:0][32:0] lnum;
        logic [3:0][15:0] lq;
        logic [31:0]      th;
        logic [46:0]      thp;
        logic [31:0]      ta;
        logic [31:0]      tb;
        logic [30:0]      sna;
        logic [30:0]      snb;
        logic             ovfa;
        logic             ovfb;
        logic [31:0]      wa;
        logic [31:0]      wb;
        logic [3:0][49:0] pa;
        logic [3:0][49:0] pb;
    } side_t;

    // clamp to the 16 bit signed range
    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [15:0] res;
        if (v > 32'sd32767) begin
            res = 16'h7fff;
        end else if (v < -32'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/qslerp_sqrt_cell.sv =====
// one digit step of the pipelined integer square root
module qslerp_sqrt_cell import qslerp_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [5:0]       bit_pos,
    input  logic [ACC_W-1:0] rem_in,
    input  logic [ACC_W-1:0] root_in,
    output logic [ACC_W-1:0] rem_reg,
    output logic [ACC_W-1:0] root_reg
);

    logic [ACC_W-1:0] bit_val;
    logic [ACC_W-1:0] trial;
    logic [ACC_W-1:0] rem_next;
    logic [ACC_W-1:0] root_next;

    // try to set this root bit
    always_comb begin
        bit_val = ACC_W'(1) << bit_pos;
        trial = root_in + bit_val;
        if (rem_in >= trial) begin
            rem_next = rem_in - trial;
            root_next = (root_in >> 1) + bit_val;
        end else begin
            rem_next = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

// ===== sv/qslerp_div_cell.sv =====
// one quotient bit of the pipelined restoring divider
module qslerp_div_cell import qslerp_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [4:0]       bit_pos,
    input  logic [ACC_W-1:0] rem_in,
    input  logic [QUO_W-1:0] quo_in,
    input  logic [31:0]      den_in,
    output logic [ACC_W-1:0] rem_reg,
    output logic [QUO_W-1:0] quo_reg,
    output logic [31:0]      den_reg
);

    logic [ACC_W-1:0] den_sh;
    logic [ACC_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;

    // subtract the shifted divisor when it fits
    always_comb begin
        den_sh = ACC_W'(den_in) << bit_pos;
        if (rem_in >= den_sh) begin
            rem_next = rem_in - den_sh;
            quo_next = quo_in | (QUO_W'(1) << bit_pos);
        end else begin
            rem_next = rem_in;
            quo_next = quo_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_in;
        end
    end

endmodule

// ===== sv/qslerp_cordic_cell.sv =====
// one micro-rotation of a pipelined cordic, vectoring or rotation mode
module qslerp_cordic_cell import qslerp_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic                  rotate,
    input  logic [4:0]            step,
    input  logic signed [CW_W-1:0] x_in,
    input  logic signed [CW_W-1:0] y_in,
    input  logic signed [CW_W-1:0] z_in,
    output logic signed [CW_W-1:0] x_reg,
    output logic signed [CW_W-1:0] y_reg,
    output logic signed [CW_W-1:0] z_reg
);

    logic signed [CW_W-1:0] xs;
    logic signed [CW_W-1:0] ys;
    logic signed [CW_W-1:0] ang;
    logic                   dir;
    logic signed [CW_W-1:0] x_next;
    logic signed [CW_W-1:0] y_next;
    logic signed [CW_W-1:0] z_next;

    // direction from residual angle (rotation) or y sign (vectoring)
    always_comb begin
        xs = x_in >>> step;
        ys = y_in >>> step;
        ang = $signed(CW_W'(ATAN_TAB[step]));
        dir = rotate ? (z_in >= 0) : (y_in > 0);
        if (dir) begin
            x_next = rotate ? x_in - ys : x_in + ys;
            y_next = rotate ? y_in + xs : y_in - xs;
            z_next = rotate ? z_in - ang : z_in + ang;
        end else begin
            x_next = rotate ? x_in + ys : x_in - ys;
            y_next = rotate ? y_in - xs : y_in + xs;
            z_next = rotate ? z_in + ang : z_in - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

// ===== sv/quaternion_slerp.sv =====
// Quaternion slerp, fully pipelined: one request per cycle. The datapath is
// built from serial chains of cells: two 32 step square roots, a 30 step
// cordic vectoring for the angle, two 30 step cordic rotations for the sine
// weights, two 32 step dividers and four linear dividers, plus multiply and
// fold stages. All stages advance together and stall together when the
// result is not taken; the input is ready whenever the output register is
// empty or being read. Configuration registers are written through the plain
// write port; the user must write them only while the pipeline is empty, as
// the block itself does not enforce it.
module quaternion_slerp import qslerp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int ST_IN = 0;
    localparam int ST_PROD = 1;
    localparam int ST_DOT = 2;
    localparam int ST_FOLD = 3;
    localparam int ST_MUL = 4;
    localparam int ST_RAD = 5;
    localparam int ST_RSQ = 6;
    localparam int ST_SQ = 7;
    localparam int ST_ROOT = ST_SQ + SQRT_STEPS + 1;
    localparam int ST_LQ = ST_ROOT + LDIV_STEPS + 1;
    localparam int ST_TH = ST_ROOT + CORDIC_STEPS + 1;
    localparam int ST_THP = ST_TH + 1;
    localparam int ST_SPLIT = ST_THP + 1;
    localparam int ST_SIN = ST_SPLIT + CORDIC_STEPS + 1;
    localparam int ST_W = ST_SIN + WDIV_STEPS + 1;
    localparam int ST_WPROD = ST_W + 1;
    localparam int SIDE_DEPTH = ST_WPROD + 1;

    logic [14:0] cos_thr_reg;
    logic [14:0] len_floor_reg;

    side_t side_reg [SIDE_DEPTH];
    side_t side_next [SIDE_DEPTH];
    logic [SIDE_DEPTH-1:0] valid_reg;
    logic  out_valid_reg;
    out_t  out_reg;
    out_t  out_next;
    logic  adv;

    // square root chains: s for the slerp path, len for the linear path
    logic [ACC_W-1:0] sqs_rem [SQRT_STEPS];
    logic [ACC_W-1:0] sqs_root [SQRT_STEPS];
    logic [ACC_W-1:0] sql_rem [SQRT_STEPS];
    logic [ACC_W-1:0] sql_root [SQRT_STEPS];

    // cordic chains
    logic signed [CW_W-1:0] vec_x [CORDIC_STEPS];
    logic signed [CW_W-1:0] vec_y [CORDIC_STEPS];
    logic signed [CW_W-1:0] vec_z [CORDIC_STEPS];
    logic signed [CW_W-1:0] rta_x [CORDIC_STEPS];
    logic signed [CW_W-1:0] rta_y [CORDIC_STEPS];
    logic signed [CW_W-1:0] rta_z [CORDIC_STEPS];
    logic signed [CW_W-1:0] rtb_x [CORDIC_STEPS];
    logic signed [CW_W-1:0] rtb_y [CORDIC_STEPS];
    logic signed [CW_W-1:0] rtb_z [CORDIC_STEPS];

    // divider chains
    logic [ACC_W-1:0] ldiv_rem [4][LDIV_STEPS];
    logic [QUO_W-1:0] ldiv_quo [4][LDIV_STEPS];
    logic [31:0]      ldiv_den [4][LDIV_STEPS];
    logic [ACC_W-1:0] wda_rem [WDIV_STEPS];
    logic [QUO_W-1:0] wda_quo [WDIV_STEPS];
    logic [31:0]      wda_den [WDIV_STEPS];
    logic [ACC_W-1:0] wdb_rem [WDIV_STEPS];
    logic [QUO_W-1:0] wdb_quo [WDIV_STEPS];
    logic [31:0]      wdb_den [WDIV_STEPS];

    // per stage helpers
    logic                    fold_neg;
    logic [33:0]             fold_c;
    logic [3:0][16:0]        fold_b2;
    logic signed [33:0]      rnd_sum [4];
    logic [30:0]             root_s;
    logic [20:0]             root_len;
    logic [17:0]             root_mag [4];
    logic [32:0]             root_num [4];
    logic [15:0]             lin_q [4];
    logic [31:0]             split_tb;
    logic [30:0]             sin_a;
    logic [30:0]             sin_b;
    logic signed [50:0]      wsum [4];
    logic [15:0]             wout [4];

    assign adv = !out_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_thr_reg <= 15'd16376;
            len_floor_reg <= 15'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COS_THRESHOLD: cos_thr_reg <= cfg_data;
                REG_LENGTH_FLOOR: len_floor_reg <= cfg_data;
                default: cos_thr_reg <= cos_thr_reg;
            endcase
        end
    end

    // valid bits move with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= {valid_reg[SIDE_DEPTH-2:0], s_valid};
            out_valid_reg <= valid_reg[SIDE_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < SIDE_DEPTH; k++) begin
                side_reg[k] <= side_next[k];
            end
            out_reg <= out_next;
        end
    end

    // sign fold for the short path
    always_comb begin
        fold_neg = side_reg[ST_DOT].dot[33];
        fold_c = fold_neg ? 34'd0 - side_reg[ST_DOT].dot : side_reg[ST_DOT].dot;
        for (int i = 0; i < 4; i++) begin
            fold_b2[i] = fold_neg ? 17'(-$signed(side_reg[ST_DOT].b2[i]))
                                  : side_reg[ST_DOT].b2[i];
        end
    end

    // linear path rounding, length and division setup
    always_comb begin
        root_s = sqs_root[SQRT_STEPS-1][30:0];
        root_len = sql_root[SQRT_STEPS-1][20:0];
        for (int i = 0; i < 4; i++) begin
            rnd_sum[i] = 34'($signed(side_reg[ST_MUL].ldp[i])) + 34'sd8192;
            root_mag[i] = side_reg[ST_ROOT-1].r[i][17] ? 18'd0 - side_reg[ST_ROOT-1].r[i]
                                                        : side_reg[ST_ROOT-1].r[i];
            root_num[i] = {1'b0, root_mag[i], 14'd0} + 33'(root_len >> 1);
        end
    end

    // linear quotient to signed saturated output
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (side_reg[ST_LQ-1].lneg[i]) begin
                lin_q[i] = (side_reg[ST_LQ-1].lovf[i] ||
                            ldiv_quo[i][LDIV_STEPS-1][15:0] > 16'd32768)
                           ? 16'h8000 : 16'd0 - ldiv_quo[i][LDIV_STEPS-1][15:0];
            end else begin
                lin_q[i] = (side_reg[ST_LQ-1].lovf[i] ||
                            ldiv_quo[i][LDIV_STEPS-1][15:0] > 16'd32767)
                           ? 16'h7fff : ldiv_quo[i][LDIV_STEPS-1][15:0];
            end
        end
    end

    // angle split and sine clamps
    always_comb begin
        split_tb = 32'((side_reg[ST_THP].thp + 47'd8192) >> FRAC_BITS);
        sin_a = rta_y[CORDIC_STEPS-1][CW_W-1] ? 31'd0 : rta_y[CORDIC_STEPS-1][30:0];
        sin_b = rtb_y[CORDIC_STEPS-1][CW_W-1] ? 31'd0 : rtb_y[CORDIC_STEPS-1][30:0];
    end

    // stage by stage data flow
    always_comb begin
        side_next[0] = side_reg[0];
        for (int k = 1; k < SIDE_DEPTH; k++) begin
            side_next[k] = side_reg[k-1];
        end

        // capture
        side_next[ST_IN].a = {s_data.a_w, s_data.a_z, s_data.a_y, s_data.a_x};
        side_next[ST_IN].b2 = {17'(s_data.b_w), 17'(s_data.b_z),
                               17'(s_data.b_y), 17'(s_data.b_x)};
        side_next[ST_IN].t = (s_data.blend > 15'(ONE)) ? 15'(ONE) : s_data.blend;

        // dot product
        for (int i = 0; i < 4; i++) begin
            side_next[ST_PROD].prod[i] = 32'($signed(side_reg[ST_IN].a[i]) *
                                             $signed(side_reg[ST_IN].b2[i]));
        end
        side_next[ST_DOT].dot = 34'($signed(side_reg[ST_PROD].prod[0]))
                              + 34'($signed(side_reg[ST_PROD].prod[1]))
                              + 34'($signed(side_reg[ST_PROD].prod[2]))
                              + 34'($signed(side_reg[ST_PROD].prod[3]));

        // fold, threshold and working cosine
        side_next[ST_FOLD].b2 = fold_b2;
        side_next[ST_FOLD].lin_thr = fold_c > {5'd0, cos_thr_reg, 14'd0};
        side_next[ST_FOLD].cw = (fold_c > 34'd268435456) ? 31'd1073741824
                                                         : {fold_c[28:0], 2'b00};
        for (int i = 0; i < 4; i++) begin
            side_next[ST_FOLD].diff[i] = 18'($signed(fold_b2[i]))
                                       - 18'($signed(side_reg[ST_DOT].a[i]));
        end

        // products
        side_next[ST_MUL].cwsq = 61'(side_reg[ST_FOLD].cw * side_reg[ST_FOLD].cw);
        for (int i = 0; i < 4; i++) begin
            side_next[ST_MUL].ldp[i] = 33'($signed(side_reg[ST_FOLD].diff[i]) *
                                           $signed({1'b0, side_reg[ST_FOLD].t}));
        end

        // sine radicand and linear blend
        side_next[ST_RAD].rad = (61'd1 << 60) - side_reg[ST_MUL].cwsq;
        for (int i = 0; i < 4; i++) begin
            side_next[ST_RAD].r[i] = 18'($signed(side_reg[ST_MUL].a[i]))
                                   + 18'(rnd_sum[i] >>> FRAC_BITS);
        end

        // squared length
        for (int i = 0; i < 4; i++) begin
            side_next[ST_RSQ].rsq[i] = 36'($signed(side_reg[ST_RAD].r[i]) *
                                           $signed(side_reg[ST_RAD].r[i]));
        end
        side_next[ST_SQ].sq = 38'(side_reg[ST_RSQ].rsq[0]) + 38'(side_reg[ST_RSQ].rsq[1])
                            + 38'(side_reg[ST_RSQ].rsq[2]) + 38'(side_reg[ST_RSQ].rsq[3]);

        // roots done: path choice and linear division setup
        side_next[ST_ROOT].s = root_s;
        side_next[ST_ROOT].len = root_len;
        side_next[ST_ROOT].use_lin = side_reg[ST_ROOT-1].lin_thr || (root_s == 31'd0);
        side_next[ST_ROOT].lin_deg = (root_len == 21'd0) ||
                                     (root_len < {6'd0, len_floor_reg});
        for (int i = 0; i < 4; i++) begin
            side_next[ST_ROOT].lneg[i] = side_reg[ST_ROOT-1].r[i][17];
            side_next[ST_ROOT].lnum[i] = root_num[i];
            side_next[ST_ROOT].lovf[i] = {4'd0, root_num[i]} >= {root_len, 16'd0};
        end

        // linear results
        for (int i = 0; i < 4; i++) begin
            side_next[ST_LQ].lq[i] = lin_q[i];
        end

        // angle, clamped at zero
        side_next[ST_TH].th = vec_z[CORDIC_STEPS-1][CW_W-1] ? 32'd0
                                                            : vec_z[CORDIC_STEPS-1][31:0];
        side_next[ST_THP].thp = 47'(side_reg[ST_TH].th * side_reg[ST_TH].t);
        side_next[ST_SPLIT].tb = split_tb;
        side_next[ST_SPLIT].ta = side_reg[ST_THP].th - split_tb;

        // sines and divider overflow check
        side_next[ST_SIN].sna = sin_a;
        side_next[ST_SIN].snb = sin_b;
        side_next[ST_SIN].ovfa = {2'd0, sin_a} >= {side_reg[ST_SIN-1].s, 2'd0};
        side_next[ST_SIN].ovfb = {2'd0, sin_b} >= {side_reg[ST_SIN-1].s, 2'd0};

        // weights capped at two
        side_next[ST_W].wa = (side_reg[ST_W-1].ovfa || wda_quo[WDIV_STEPS-1] > 32'h8000_0000)
                             ? 32'h8000_0000 : wda_quo[WDIV_STEPS-1];
        side_next[ST_W].wb = (side_reg[ST_W-1].ovfb || wdb_quo[WDIV_STEPS-1] > 32'h8000_0000)
                             ? 32'h8000_0000 : wdb_quo[WDIV_STEPS-1];

        // weighted components
        for (int i = 0; i < 4; i++) begin
            side_next[ST_WPROD].pa[i] = 50'($signed(side_reg[ST_W].a[i]) *
                                            $signed({1'b0, side_reg[ST_W].wa}));
            side_next[ST_WPROD].pb[i] = 50'($signed(side_reg[ST_W].b2[i]) *
                                            $signed({1'b0, side_reg[ST_W].wb}));
        end
    end

    // final sum, rounding and path select
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            wsum[i] = 51'($signed(side_reg[ST_WPROD].pa[i]))
                    + 51'($signed(side_reg[ST_WPROD].pb[i])) + 51'sd536870912;
            wout[i] = sat16(32'(wsum[i] >>> 30));
        end
        if (!side_reg[ST_WPROD].use_lin) begin
            out_next = {wout[0], wout[1], wout[2], wout[3], 1'b0};
        end else if (side_reg[ST_WPROD].lin_deg) begin
            out_next = {16'd0, 16'd0, 16'd0, sat16(32'(ONE)), 1'b1};
        end else begin
            out_next = {side_reg[ST_WPROD].lq[0], side_reg[ST_WPROD].lq[1],
                        side_reg[ST_WPROD].lq[2], side_reg[ST_WPROD].lq[3], 1'b0};
        end
    end

    // square root chains
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [ACC_W-1:0] s_rem_in;
        logic [ACC_W-1:0] s_root_in;
        logic [ACC_W-1:0] l_rem_in;
        logic [ACC_W-1:0] l_root_in;
        if (j == 0) begin : g_head
            assign s_rem_in = ACC_W'(side_reg[ST_SQ].rad);
            assign s_root_in = '0;
            assign l_rem_in = ACC_W'(side_reg[ST_SQ].sq);
            assign l_root_in = '0;
        end else begin : g_link
            assign s_rem_in = sqs_rem[j-1];
            assign s_root_in = sqs_root[j-1];
            assign l_rem_in = sql_rem[j-1];
            assign l_root_in = sql_root[j-1];
        end
        qslerp_sqrt_cell u_sine (
            .aclk     (aclk),
            .en       (adv),
            .bit_pos  (6'(2 * (SQRT_STEPS - 1 - j))),
            .rem_in   (s_rem_in),
            .root_in  (s_root_in),
            .rem_reg  (sqs_rem[j]),
            .root_reg (sqs_root[j])
        );
        qslerp_sqrt_cell u_len (
            .aclk     (aclk),
            .en       (adv),
            .bit_pos  (6'(2 * (SQRT_STEPS - 1 - j))),
            .rem_in   (l_rem_in),
            .root_in  (l_root_in),
            .rem_reg  (sql_rem[j]),
            .root_reg (sql_root[j])
        );
    end

    // cordic chains: angle from (c, s), then sines of both weights
    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        logic signed [CW_W-1:0] vx_in, vy_in, vz_in;
        logic signed [CW_W-1:0] ax_in, ay_in, az_in;
        logic signed [CW_W-1:0] bx_in, by_in, bz_in;
        if (j == 0) begin : g_head
            assign vx_in = $signed(CW_W'(side_reg[ST_ROOT].cw));
            assign vy_in = $signed(CW_W'(side_reg[ST_ROOT].s));
            assign vz_in = '0;
            assign ax_in = $signed(CW_W'(CORDIC_KINV));
            assign ay_in = '0;
            assign az_in = $signed(CW_W'(side_reg[ST_SPLIT].ta));
            assign bx_in = $signed(CW_W'(CORDIC_KINV));
            assign by_in = '0;
            assign bz_in = $signed(CW_W'(side_reg[ST_SPLIT].tb));
        end else begin : g_link
            assign vx_in = vec_x[j-1];
            assign vy_in = vec_y[j-1];
            assign vz_in = vec_z[j-1];
            assign ax_in = rta_x[j-1];
            assign ay_in = rta_y[j-1];
            assign az_in = rta_z[j-1];
            assign bx_in = rtb_x[j-1];
            assign by_in = rtb_y[j-1];
            assign bz_in = rtb_z[j-1];
        end
        qslerp_cordic_cell u_vec (
            .aclk   (aclk),
            .en     (adv),
            .rotate (1'b0),
            .step   (5'(j)),
            .x_in   (vx_in),
            .y_in   (vy_in),
            .z_in   (vz_in),
            .x_reg  (vec_x[j]),
            .y_reg  (vec_y[j]),
            .z_reg  (vec_z[j])
        );
        qslerp_cordic_cell u_rot_a (
            .aclk   (aclk),
            .en     (adv),
            .rotate (1'b1),
            .step   (5'(j)),
            .x_in   (ax_in),
            .y_in   (ay_in),
            .z_in   (az_in),
            .x_reg  (rta_x[j]),
            .y_reg  (rta_y[j]),
            .z_reg  (rta_z[j])
        );
        qslerp_cordic_cell u_rot_b (
            .aclk   (aclk),
            .en     (adv),
            .rotate (1'b1),
            .step   (5'(j)),
            .x_in   (bx_in),
            .y_in   (by_in),
            .z_in   (bz_in),
            .x_reg  (rtb_x[j]),
            .y_reg  (rtb_y[j]),
            .z_reg  (rtb_z[j])
        );
    end

    // linear normalize dividers, one chain per component
    for (genvar c = 0; c < 4; c++) begin : g_ldiv
        for (genvar j = 0; j < LDIV_STEPS; j++) begin : g_step
            logic [ACC_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;
            logic [31:0]      den_in;
            if (j == 0) begin : g_head
                assign rem_in = ACC_W'(side_reg[ST_ROOT].lnum[c]);
                assign quo_in = '0;
                assign den_in = 32'(side_reg[ST_ROOT].len);
            end else begin : g_link
                assign rem_in = ldiv_rem[c][j-1];
                assign quo_in = ldiv_quo[c][j-1];
                assign den_in = ldiv_den[c][j-1];
            end
            qslerp_div_cell u_div (
                .aclk    (aclk),
                .en      (adv),
                .bit_pos (5'(LDIV_STEPS - 1 - j)),
                .rem_in  (rem_in),
                .quo_in  (quo_in),
                .den_in  (den_in),
                .rem_reg (ldiv_rem[c][j]),
                .quo_reg (ldiv_quo[c][j]),
                .den_reg (ldiv_den[c][j])
            );
        end
    end

    // weight dividers, sine over s
    for (genvar j = 0; j < WDIV_STEPS; j++) begin : g_wdiv
        logic [ACC_W-1:0] a_rem_in, b_rem_in;
        logic [QUO_W-1:0] a_quo_in, b_quo_in;
        logic [31:0]      a_den_in, b_den_in;
        if (j == 0) begin : g_head
            assign a_rem_in = ACC_W'({side_reg[ST_SIN].sna, 30'd0});
            assign b_rem_in = ACC_W'({side_reg[ST_SIN].snb, 30'd0});
            assign a_quo_in = '0;
            assign b_quo_in = '0;
            assign a_den_in = 32'(side_reg[ST_SIN].s);
            assign b_den_in = 32'(side_reg[ST_SIN].s);
        end else begin : g_link
            assign a_rem_in = wda_rem[j-1];
            assign b_rem_in = wdb_rem[j-1];
            assign a_quo_in = wda_quo[j-1];
            assign b_quo_in = wdb_quo[j-1];
            assign a_den_in = wda_den[j-1];
            assign b_den_in = wdb_den[j-1];
        end
        qslerp_div_cell u_div_a (
            .aclk    (aclk),
            .en      (adv),
            .bit_pos (5'(WDIV_STEPS - 1 - j)),
            .rem_in  (a_rem_in),
            .quo_in  (a_quo_in),
            .den_in  (a_den_in),
            .rem_reg (wda_rem[j]),
            .quo_reg (wda_quo[j]),
            .den_reg (wda_den[j])
        );
        qslerp_div_cell u_div_b (
            .aclk    (aclk),
            .en      (adv),
            .bit_pos (5'(WDIV_STEPS - 1 - j)),
            .rem_in  (b_rem_in),
            .quo_in  (b_quo_in),
            .den_in  (b_den_in),
            .rem_reg (wdb_rem[j]),
            .quo_reg (wdb_quo[j]),
            .den_reg (wdb_den[j])
        );
    end

endmodule

// ===== sv/qslerp_checks.sv =====
// port level checks for the quaternion slerp block, bound to the top level
module qslerp_checks import qslerp_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a held result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a stalled output stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline stalled");

    // degenerate flag always comes with the identity quaternion
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.r_x == 16'sd0 && m_data.r_y == 16'sd0 &&
            m_data.r_z == 16'sd0 && m_data.r_w == 16'sd16384)
        else $error("degenerate result is not identity");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind quaternion_slerp qslerp_checks u_qslerp_checks (.*);

// ===== bench/quaternion_slerp_tb.sv =====
// self-checking testbench for the quaternion slerp pipeline
`timescale 1ns / 100ps

module quaternion_slerp_tb;
    import qslerp_pkg::*;

    localparam int CYCLE_NS = 2;
    localparam int PIPE_LAT = 140;
    localparam longint FULL_Q28 = 64'sd1 << 28;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_COS_THRESHOLD;
    logic [14:0] cfg_data = '0;

    quaternion_slerp dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #(CYCLE_NS / 2) aclk = ~aclk;

    // shadow copy of the configuration registers
    longint cos_thr_shadow = 16376;
    longint len_floor_shadow = 1;
    longint atan_rom [CORDIC_STEPS];

    out_t expected_q [$];
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;

    // directed requests, expected value typed in where it is obvious
    typedef struct {
        in_t  req;
        bit   fixed;
        out_t res;
    } vec_t;

    // atan(2^-i) in Q1.30 from the Taylor series in Q2.62
    function automatic longint atan_entry(int i);
        longint unsigned acc, term;
        int e;
        if (i == 0) return 843314857;
        acc = 0;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 62) break;
            term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
            if (k % 2) acc = acc - term;
            else acc = acc + term;
        end
        return longint'((acc + (64'd1 << 31)) >> 32);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // vectoring: angle of (x, y)
    function automatic longint cordic_theta(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + atan_rom[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_rom[i];
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    // rotation: sine of z
    function automatic longint cordic_sine(longint z);
        longint x, y, xs, ys;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_rom[i];
            end else begin
                x = x + ys; y = y - xs; z = z + atan_rom[i];
            end
        end
        return (y < 0) ? 0 : y;
    endfunction

    function automatic longint sine_weight(longint sn, longint s);
        longint w;
        w = (sn * (64'sd1 << 30)) / s;
        return (w > (64'sd1 << 31)) ? (64'sd1 << 31) : w;
    endfunction

    // expected interpolation result for one request
    function automatic out_t slerp_expect(in_t q);
        longint a [4];
        longint b [4];
        longint r [4];
        longint t, dot, c, cw, s, th, tb, ta, wa, wb, qv;
        longint unsigned sq, len, mag;
        out_t o;
        a[0] = $signed(q.a_x); a[1] = $signed(q.a_y);
        a[2] = $signed(q.a_z); a[3] = $signed(q.a_w);
        b[0] = $signed(q.b_x); b[1] = $signed(q.b_y);
        b[2] = $signed(q.b_z); b[3] = $signed(q.b_w);
        t = q.blend;
        if (t > ONE) t = ONE;
        dot = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        // take the short path
        if (dot < 0) begin
            dot = -dot;
            for (int i = 0; i < 4; i++) b[i] = -b[i];
        end
        // true slerp at or below the threshold unless the sine vanishes
        if (dot <= (cos_thr_shadow << FRAC_BITS)) begin
            c = (dot > FULL_Q28) ? FULL_Q28 : dot;
            cw = c << 2;
            s = longint'(root64((64'd1 << 60) - longint'(cw) * longint'(cw)));
            if (s != 0) begin
                th = cordic_theta(cw, s);
                tb = (th * t + ONE / 2) >>> FRAC_BITS;
                ta = th - tb;
                wa = sine_weight(cordic_sine(ta), s);
                wb = sine_weight(cordic_sine(tb), s);
                o.r_x = clip16((a[0] * wa + b[0] * wb + (64'sd1 << 29)) >>> 30);
                o.r_y = clip16((a[1] * wa + b[1] * wb + (64'sd1 << 29)) >>> 30);
                o.r_z = clip16((a[2] * wa + b[2] * wb + (64'sd1 << 29)) >>> 30);
                o.r_w = clip16((a[3] * wa + b[3] * wb + (64'sd1 << 29)) >>> 30);
                o.degenerate = 1'b0;
                return o;
            end
        end
        // linear blend and normalize
        sq = 0;
        for (int i = 0; i < 4; i++) begin
            r[i] = a[i] + (((b[i] - a[i]) * t + ONE / 2) >>> FRAC_BITS);
            sq = sq + longint'(r[i] * r[i]);
        end
        len = root64(sq);
        if (len == 0 || len < len_floor_shadow) begin
            o = '{16'sd0, 16'sd0, 16'sd0, clip16(ONE), 1'b1};
            return o;
        end
        for (int i = 0; i < 4; i++) begin
            mag = longint'(r[i] < 0 ? -r[i] : r[i]) * ONE;
            qv = longint'((mag + len / 2) / len);
            r[i] = (r[i] < 0) ? -qv : qv;
        end
        o.r_x = clip16(r[0]); o.r_y = clip16(r[1]);
        o.r_z = clip16(r[2]); o.r_w = clip16(r[3]);
        o.degenerate = 1'b0;
        return o;
    endfunction

    // result side: stall control and checking
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d w=%0d deg=%0b",
                             m_data.r_x, m_data.r_y, m_data.r_z, m_data.r_w,
                             m_data.degenerate);
            end else begin
                out_t exp_r;
                exp_r = expected_q.pop_front();
                if (m_data.r_x !== exp_r.r_x || m_data.r_y !== exp_r.r_y ||
                    m_data.r_z !== exp_r.r_z || m_data.r_w !== exp_r.r_w ||
                    m_data.degenerate !== exp_r.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d deg=%0b got %0d %0d %0d %0d deg=%0b",
                                 exp_r.r_x, exp_r.r_y, exp_r.r_z, exp_r.r_w,
                                 exp_r.degenerate, m_data.r_x, m_data.r_y,
                                 m_data.r_z, m_data.r_w, m_data.degenerate);
                end
            end
        end
    end

    // offer one request and wait for acceptance; valid drops only while idle
    task automatic send_request(in_t q, bit fixed, out_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= q;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        expected_q.push_back(fixed ? res : slerp_expect(q));
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [14:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_COS_THRESHOLD) cos_thr_shadow = val;
        else len_floor_shadow = val;
        @(posedge aclk);
    endtask

    // random unit quaternion, optionally near a given one
    function automatic void unit_quat(output logic signed [15:0] v [4],
                                      input logic signed [15:0] near [4],
                                      input int spread);
        real c [4];
        real n;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            if (spread > 0)
                c[i] = real'(near[i]) + real'(int'($urandom_range(2 * spread)) - spread);
            else
                c[i] = real'($urandom_range(65535)) - 32768.0;
            n += c[i] * c[i];
        end
        if (n < 1.0) begin
            c[3] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        for (int i = 0; i < 4; i++) v[i] = 16'($rtoi(c[i] * 16384.0 / n));
    endfunction

    function automatic in_t random_request();
        logic signed [15:0] qa [4];
        logic signed [15:0] qb [4];
        in_t q;
        int kind;
        kind = $urandom_range(99);
        unit_quat(qa, qa, 0);
        if (kind < 30) begin
            unit_quat(qb, qa, 1 << $urandom_range(8));
            if ($urandom_range(1)) for (int i = 0; i < 4; i++) qb[i] = -qb[i];
        end else if (kind < 75) begin
            unit_quat(qb, qa, 0);
        end else begin
            for (int i = 0; i < 4; i++) begin
                qa[i] = 16'($urandom);
                qb[i] = 16'($urandom);
            end
        end
        q = {qa[0], qa[1], qa[2], qa[3], qb[0], qb[1], qb[2], qb[3], 15'd0};
        if ($urandom_range(9) == 0) q.blend = 15'($urandom);
        else q.blend = 15'($urandom_range(ONE));
        return q;
    endfunction

    // edges of the fields and the named special cases
    vec_t directed [] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 15'd0},
          1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 15'd0},
          1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
            -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 15'd0},
          1'b1, '{-16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192, 1'b0}},
        '{'{16'sd12000, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 15'd0},
          1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd8192},
          1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 15'd8192},
          1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 15'd16384},
          1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 15'h7fff},
          1'b0, '0},
        '{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0, -16'sd11585,
            15'd4096}, 1'b0, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
            -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 15'd12000}, 1'b0, '0},
        '{'{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192,
            16'sd8200, -16'sd8190, 16'sd8192, -16'sd8192, 15'd16383}, 1'b0, '0},
        '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 15'd1},
          1'b0, '0},
        '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 15'd10000},
          1'b0, '0}
    };

    // phase settings: thresholds, floors and idling mode
    logic [14:0] phase_thr [6] = '{15'd16376, 15'd0, 15'd16384, 15'd16000, 15'd16383, 15'd9000};
    logic [14:0] phase_floor [6] = '{15'd1, 15'd0, 15'd16384, 15'd16383, 15'd8000, 15'd1};

    initial begin
        for (int i = 0; i < CORDIC_STEPS; i++) atan_rom[i] = atan_entry(i);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass with wide threshold and floor
        write_reg(REG_COS_THRESHOLD, 15'd16384);
        write_reg(REG_LENGTH_FLOOR, 15'd16384);
        foreach (directed[i]) send_request(directed[i].req, directed[i].fixed, directed[i].res);
        drain_pipe();

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_COS_THRESHOLD, phase_thr[ph]);
            write_reg(REG_LENGTH_FLOOR, phase_floor[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 77; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 77; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            // long receiver hold-off so the pipeline backs up
            if (ph == 0) hold_cycles = 400;
            for (int n = 0; n < 208; n++) send_request(random_request(), 1'b0, '0);
            drain_pipe();
        end

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(2000000 * CYCLE_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/qslerp_pkg.sv
sv/qslerp_sqrt_cell.sv
sv/qslerp_div_cell.sv
sv/qslerp_cordic_cell.sv
sv/quaternion_slerp.sv
sv/qslerp_checks.sv
bench/quaternion_slerp_tb.sv
